// ===== rtl/htte_pkg.sv =====
// ----------------------------------------------------------------------------
// htte_pkg
// types, character codes and keyword tables for the html text extractor
// ----------------------------------------------------------------------------
package htte_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 3;

  localparam logic [ByteW-1:0] ChLt    = 8'h3C;
  localparam logic [ByteW-1:0] ChGt    = 8'h3E;
  localparam logic [ByteW-1:0] ChAmp   = 8'h26;
  localparam logic [ByteW-1:0] ChNl    = 8'h0A;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChT     = 8'h74;
  localparam logic [ByteW-1:0] ChR     = 8'h72;
  localparam logic [ByteW-1:0] ChD     = 8'h64;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;

  localparam logic [PosW-1:0] PosDead   = 3'd7;
  localparam logic [PosW-1:0] TitleLen  = 3'd5;
  localparam logic [PosW-1:0] BodyLen   = 3'd4;
  localparam logic [PosW-1:0] EntityLen = 3'd6;

  typedef enum logic [5:0] {
    PH_SEEK_TITLE = 6'b000001,
    PH_TITLE_OPEN = 6'b000010,
    PH_TITLE_TEXT = 6'b000100,
    PH_SEEK_BODY  = 6'b001000,
    PH_BODY_OPEN  = 6'b010000,
    PH_BODY       = 6'b100000
  } phase_t;

  // results of one input beat: a held entity prefix, then an optional byte
  typedef struct packed {
    logic [PosW-1:0]  prefix_len;
    logic             extra_valid;
    logic [ByteW-1:0] extra_char;
    logic             extra_title;
    logic             done;
    logic [PosW-1:0]  last_idx;
  } run_t;

  function automatic logic [ByteW-1:0] title_char(input logic [PosW-1:0] pos);
    logic [ByteW-1:0] c;
    unique case (pos)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h69;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h6C;
      3'd4:    c = 8'h65;
      default: c = ChNul;
    endcase
    return c;
  endfunction

  function automatic logic [ByteW-1:0] body_char(input logic [PosW-1:0] pos);
    logic [ByteW-1:0] c;
    unique case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h64;
      3'd3:    c = 8'h79;
      default: c = ChNul;
    endcase
    return c;
  endfunction

  function automatic logic [ByteW-1:0] nbsp_char(input logic [PosW-1:0] pos);
    logic [ByteW-1:0] c;
    unique case (pos)
      3'd0:    c = 8'h26;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h62;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h70;
      3'd5:    c = 8'h3B;
      default: c = ChNul;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/htte_if.sv =====
// ----------------------------------------------------------------------------
// htte_if
// valid/ready channels for page bytes in and text bytes out
// ----------------------------------------------------------------------------
interface htte_page_if;
  logic       valid;
  logic       ready;
  logic [7:0] page_byte;
  logic       end_of_page;

  modport source (output valid, page_byte, end_of_page, input ready);
  modport sink   (input valid, page_byte, end_of_page, output ready);
endinterface

interface htte_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       is_title;
  logic       last_of_run;
  logic       page_done;

  modport source (output valid, text_char, is_title, last_of_run, page_done, input ready);
  modport sink   (input valid, text_char, is_title, last_of_run, page_done, output ready);
endinterface

// ===== rtl/html_title_and_table_text_extractor.sv =====
// ----------------------------------------------------------------------------
// html_title_and_table_text_extractor
// extracts title text and body text (rows as newline, cells as tab) from html
// ----------------------------------------------------------------------------
// result: first result beat is registered, shown in the cycle after the page beat is taken
// throughput: one page beat per cycle while each beat gives at most one result
//   and text is ready; the single result register makes a beat with more results
//   (replay of a broken "&nbsp" prefix, up to six beats) hold the input until taken
// reset: synchronous rst returns to seeking the title tag, result register empty
module html_title_and_table_text_extractor (
  input  logic       clk,
  input  logic       rst,
  htte_page_if.sink  page,
  htte_text_if.source text
);

  htte_pkg::phase_t      phase, phase_next;
  logic [htte_pkg::PosW-1:0] tag_pos, tag_pos_next;
  logic [htte_pkg::PosW-1:0] ent_pos, ent_pos_next;
  logic                  inside_tag, inside_tag_next;

  htte_pkg::run_t        run, run_next;
  logic                  run_valid;
  logic [htte_pkg::PosW-1:0] beat_idx;
  logic                  final_beat;
  logic                  accept;

  logic [htte_pkg::ByteW-1:0] c;
  logic                  seek_en, seek_body;
  logic [htte_pkg::ByteW-1:0] word_c;
  logic [htte_pkg::PosW-1:0]  word_len;
  logic [htte_pkg::PosW-1:0]  rep_len;
  logic                  ext_v;
  logic [htte_pkg::ByteW-1:0] ext_c;
  logic                  ext_t;

  assign c          = page.page_byte;
  assign final_beat = (beat_idx == run.last_idx);
  assign page.ready = !run_valid || (text.ready && final_beat);
  assign accept     = page.valid && page.ready;

  always_comb begin
    phase_next      = phase;
    tag_pos_next    = tag_pos;
    ent_pos_next    = ent_pos;
    inside_tag_next = inside_tag;
    seek_en         = 1'b0;
    seek_body       = 1'b0;
    rep_len         = '0;
    ext_v           = 1'b0;
    ext_c           = c;
    ext_t           = 1'b0;

    unique case (phase)
      htte_pkg::PH_TITLE_OPEN: begin
        if (c == htte_pkg::ChGt) begin
          phase_next      = htte_pkg::PH_TITLE_TEXT;
          inside_tag_next = 1'b0;
        end
      end
      htte_pkg::PH_TITLE_TEXT: begin
        if (c == htte_pkg::ChLt) begin
          phase_next      = htte_pkg::PH_SEEK_BODY;
          inside_tag_next = 1'b1;
          tag_pos_next    = '0;
        end else begin
          ext_v = 1'b1;
          ext_t = 1'b1;
        end
      end
      htte_pkg::PH_SEEK_BODY: begin
        seek_en   = 1'b1;
        seek_body = 1'b1;
      end
      htte_pkg::PH_BODY_OPEN: begin
        if (c == htte_pkg::ChGt) begin
          phase_next      = htte_pkg::PH_BODY;
          inside_tag_next = 1'b0;
          tag_pos_next    = '0;
          ent_pos_next    = '0;
        end
      end
      htte_pkg::PH_BODY: begin
        if (inside_tag) begin
          if (c == htte_pkg::ChLt) begin
            tag_pos_next = '0;
          end else if (c == htte_pkg::ChGt) begin
            inside_tag_next = 1'b0;
            tag_pos_next    = '0;
          end else if (tag_pos == 3'd0) begin
            tag_pos_next = (c == htte_pkg::ChT) ? 3'd1 : htte_pkg::PosDead;
          end else if (tag_pos == 3'd1) begin
            if (c == htte_pkg::ChR) begin
              ext_v = 1'b1;
              ext_c = htte_pkg::ChNl;
            end else if (c == htte_pkg::ChD) begin
              ext_v = 1'b1;
              ext_c = htte_pkg::ChTab;
            end
            tag_pos_next = htte_pkg::PosDead;
          end
        end else if (ent_pos != 3'd0 && ent_pos < htte_pkg::EntityLen &&
                     c == htte_pkg::nbsp_char(ent_pos)) begin
          ent_pos_next = (ent_pos + 3'd1 == htte_pkg::EntityLen) ? 3'd0 : ent_pos + 3'd1;
        end else begin
          rep_len      = ent_pos;
          ent_pos_next = '0;
          if (c == htte_pkg::ChAmp) begin
            ent_pos_next = 3'd1;
          end else if (c == htte_pkg::ChLt) begin
            inside_tag_next = 1'b1;
            tag_pos_next    = '0;
          end else if (c != htte_pkg::ChNl) begin
            ext_v = 1'b1;
          end
        end
      end
      default: begin
        phase_next = htte_pkg::PH_SEEK_TITLE;
        seek_en    = 1'b1;
      end
    endcase

    word_c   = seek_body ? htte_pkg::body_char(tag_pos) : htte_pkg::title_char(tag_pos);
    word_len = seek_body ? htte_pkg::BodyLen : htte_pkg::TitleLen;
    if (seek_en) begin
      if (c == htte_pkg::ChLt) begin
        inside_tag_next = 1'b1;
        tag_pos_next    = '0;
      end else if (inside_tag) begin
        if (c == htte_pkg::ChGt) begin
          inside_tag_next = 1'b0;
          tag_pos_next    = '0;
        end else if (tag_pos < word_len && c == word_c) begin
          if (tag_pos + 3'd1 == word_len) begin
            phase_next   = seek_body ? htte_pkg::PH_BODY_OPEN : htte_pkg::PH_TITLE_OPEN;
            tag_pos_next = '0;
          end else begin
            tag_pos_next = tag_pos + 3'd1;
          end
        end else begin
          tag_pos_next = htte_pkg::PosDead;
        end
      end
    end

    // page end: flush a held prefix, or give an empty marker beat
    if (page.end_of_page) begin
      if (ent_pos_next != 3'd0) begin
        if (rep_len == 3'd0) begin
          rep_len = ent_pos_next;
        end else begin
          ext_v = 1'b1;
          ext_c = htte_pkg::ChAmp;
          ext_t = 1'b0;
        end
      end
      if (rep_len == 3'd0 && !ext_v) begin
        ext_v = 1'b1;
        ext_c = htte_pkg::ChNul;
        ext_t = 1'b0;
      end
      phase_next      = htte_pkg::PH_SEEK_TITLE;
      tag_pos_next    = '0;
      ent_pos_next    = '0;
      inside_tag_next = 1'b0;
    end

    run_next.prefix_len  = rep_len;
    run_next.extra_valid = ext_v;
    run_next.extra_char  = ext_c;
    run_next.extra_title = ext_t;
    run_next.done        = page.end_of_page;
    run_next.last_idx    = rep_len + {2'b00, ext_v} - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= htte_pkg::PH_SEEK_TITLE;
      tag_pos    <= '0;
      ent_pos    <= '0;
      inside_tag <= 1'b0;
      run_valid  <= 1'b0;
      beat_idx   <= '0;
    end else begin
      if (accept && (run_next.extra_valid || run_next.prefix_len != 3'd0)) begin
        run_valid <= 1'b1;
        beat_idx  <= '0;
      end else if (text.valid && text.ready) begin
        beat_idx <= beat_idx + 3'd1;
        if (final_beat) begin
          run_valid <= 1'b0;
        end
      end
      if (accept) begin
        phase      <= phase_next;
        tag_pos    <= tag_pos_next;
        ent_pos    <= ent_pos_next;
        inside_tag <= inside_tag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run <= run_next;
    end
  end

  assign text.valid       = run_valid;
  assign text.text_char   = (beat_idx < run.prefix_len) ? htte_pkg::nbsp_char(beat_idx)
                                                        : run.extra_char;
  assign text.is_title    = (beat_idx < run.prefix_len) ? 1'b0 : run.extra_title;
  assign text.last_of_run = final_beat;
  assign text.page_done   = final_beat && run.done;

  a_page_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && page.end_of_page) |=>
      (phase == htte_pkg::PH_SEEK_TITLE && ent_pos == 3'd0 &&
       tag_pos == 3'd0 && !inside_tag))
    else $error("state not cleared after page end");

  a_entity_bound: assert property (@(posedge clk) disable iff (rst)
    ent_pos < htte_pkg::EntityLen)
    else $error("entity prefix count out of range");

  a_title_single: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.is_title) |-> text.last_of_run)
    else $error("title beat not alone in its run");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.page_done) |-> text.last_of_run)
    else $error("page done away from end of run");

endmodule
